/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the register access master.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every edge outside reset
`define ASSERT_IMPL(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked during reset as well
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* rtl/i2c_ram_pkg.sv */
// ----------------------------------------------------------------------------
// I2C register access master package
// Shared types, codes and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none
package i2c_ram_pkg;
   localparam int MAX_BYTES = 4;

   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;

   localparam logic CSR_DEV_ADDR = 1'b0;
   localparam logic CSR_ACK_TMO  = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE, PH_START, PH_SEND, PH_ACKW, PH_POLL, PH_TOSTOP,
      PH_RECV, PH_ACKOUT, PH_NACKOUT, PH_STOP
   } phase_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic [7:0] rdata;
      logic       rvalid;
      logic       done;
      logic       err;
      logic       busy;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic        is_read;
      logic [15:0] reg_addr;
      logic [31:0] wdata;
      logic [2:0]  cnt;
      logic        sda;
   } cmd_type;
endpackage
`default_nettype wire

/* rtl/i2c_ram_front.sv */
// ----------------------------------------------------------------------------
// I2C register access master front end
// Accepts request words, classifies the action and saturates the count.
// ----------------------------------------------------------------------------
`default_nettype none
module i2c_ram_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_action,
   input  wire logic [15:0]          req_reg_addr,
   input  wire logic [31:0]          req_write_data,
   input  wire logic [2:0]           req_byte_count,
   input  wire logic                 req_sda_in,
   output logic                      cmd_valid,
   input  wire logic                 cmd_ready,
   output i2c_ram_pkg::cmd_type      cmd
);
   import i2c_ram_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic [2:0] cnt;

   assign req_ready = !valid_ff || cmd_ready;
   assign cnt = (req_byte_count > 3'(MAX_BYTES)) ? 3'(MAX_BYTES) : req_byte_count;

   always_comb begin
      valid_in = valid_ff;
      cmd_in = cmd_ff;
      if (req_ready) begin
         valid_in = req_valid;
         cmd_in.start = (req_action == ACT_READ) || (req_action == ACT_WRITE);
         cmd_in.is_read = (req_action == ACT_READ);
         cmd_in.reg_addr = req_reg_addr;
         cmd_in.wdata = req_write_data;
         cmd_in.cnt = cnt;
         cmd_in.sda = req_sda_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd = cmd_ff;
endmodule
`default_nettype wire

/* rtl/i2c_ram_queue.sv */
// ----------------------------------------------------------------------------
// I2C register access master command queue
// Two-entry queue between the front end and the bus sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module i2c_ram_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire i2c_ram_pkg::cmd_type in_cmd,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output i2c_ram_pkg::cmd_type      out_cmd
);
   import i2c_ram_pkg::*;

   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign out_cmd = mem_ff[rp_ff];

   always_comb begin
      wp_in = push ? !wp_ff : wp_ff;
      rp_in = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_cmd;
   end

   `ASSERT_ALWAYS(a_cnt_range, clock, reset || (cnt_ff != 2'd3), "queue count out of range")
   `ASSERT_IMPL(a_no_over, clock, reset, (cnt_ff == 2'd2) |-> !push, "queue overflow")
   `ASSERT_IMPL(a_ptr, clock, reset, (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> (wp_ff == rp_ff),
      "queue pointers disagree with count")
endmodule
`default_nettype wire

/* rtl/i2c_ram_seq.sv */
// ----------------------------------------------------------------------------
// I2C register access master bus sequencer
// Advances the bus one delay interval per command and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module i2c_ram_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic                 csr_index,
   input  wire logic [7:0]           csr_write_data,
   input  wire logic                 cmd_valid,
   output logic                      cmd_ready,
   input  wire i2c_ram_pkg::cmd_type cmd,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output i2c_ram_pkg::rsp_type      rsp
);
   import i2c_ram_pkg::*;

   logic [6:0]  dev_ff;
   logic [7:0]  tmo_ff;
   phase_type   ph_ff, ph_in;
   logic [3:0]  bit_ff, bit_in;
   logic [2:0]  byte_ff, byte_in;
   logic [7:0]  sh_ff, sh_in;
   logic [7:0]  wait_ff, wait_in;
   logic [31:0] pend_ff, pend_in;
   logic [15:0] sreg_ff, sreg_in;
   logic [2:0]  scnt_ff, scnt_in;
   logic        rd_ff, rd_in, err_ff, err_in;
   logic        scl_ff, scl_in, sda_ff, sda_in;
   logic        ov_ff;
   rsp_type     out_ff, out_in;
   logic        fire;
   phase_type   ph;
   logic [3:0]  bc;

   assign cmd_ready = !ov_ff || rsp_ready;
   assign fire = cmd_valid && cmd_ready;
   assign rsp_valid = ov_ff;
   assign rsp = out_ff;

   always_comb begin
      logic [7:0] addr;
      logic       ack_go, ack_to;
      addr = '0;
      ack_go = 1'b0;
      ack_to = 1'b0;
      ph_in = ph_ff; bit_in = bit_ff; byte_in = byte_ff; sh_in = sh_ff;
      wait_in = wait_ff; pend_in = pend_ff; sreg_in = sreg_ff; scnt_in = scnt_ff;
      rd_in = rd_ff; err_in = err_ff; scl_in = scl_ff; sda_in = sda_ff;
      out_in = '0;
      ph = ph_ff;
      if (ph_ff == PH_IDLE && cmd.start) begin
         sreg_in = cmd.reg_addr;
         pend_in = cmd.wdata;
         scnt_in = cmd.cnt;
         rd_in = cmd.is_read;
         err_in = 1'b0;
         byte_in = 3'd0;
         wait_in = 8'd0;
         ph = PH_START;
         bit_in = 4'd0;
      end
      bc = bit_in;
      unique case (ph)
         PH_START: begin
            if (bc == 4'd0) begin
               scl_in = 1'b1; sda_in = 1'b1; bit_in = bc + 4'd1;
            end else if (bc == 4'd1) begin
               scl_in = 1'b1; sda_in = 1'b0; bit_in = bc + 4'd1;
            end else begin
               addr = {dev_ff, (byte_in == 3'd3)};
               scl_in = 1'b0; sda_in = 1'b0;
               sh_in = addr; ph = PH_SEND; bit_in = 4'd0;
            end
            ph_in = ph;
         end
         PH_SEND: begin
            ph_in = ph;
            if (!bc[0]) begin
               scl_in = 1'b0; sda_in = sh_ff[7]; bit_in = bc + 4'd1;
            end else begin
               scl_in = 1'b1;
               sh_in = {sh_ff[6:0], 1'b0};
               if (bc == 4'd15) begin
                  ph_in = PH_ACKW; bit_in = 4'd0;
               end else bit_in = bc + 4'd1;
            end
         end
         PH_ACKW: begin
            if (bc == 4'd0) begin
               scl_in = 1'b0; sda_in = 1'b1; bit_in = 4'd1; ph_in = ph;
            end else begin
               scl_in = 1'b1; sda_in = 1'b1; wait_in = 8'd0;
               ph_in = PH_POLL; bit_in = 4'd0;
            end
         end
         PH_POLL: begin
            ph_in = ph;
            if (!cmd.sda) begin
               scl_in = 1'b0; sda_in = 1'b1; ack_go = 1'b1;
            end else if (wait_ff >= tmo_ff) begin
               err_in = 1'b1; scl_in = 1'b1; sda_in = 1'b0;
               ph_in = PH_TOSTOP; bit_in = 4'd0;
            end else begin
               wait_in = wait_ff + 8'd1; scl_in = 1'b1; sda_in = 1'b1;
            end
         end
         PH_TOSTOP: begin
            ph_in = ph;
            if (bc == 4'd0) begin
               scl_in = 1'b1; sda_in = 1'b0; bit_in = 4'd1;
            end else if (bc == 4'd1) begin
               scl_in = 1'b1; sda_in = 1'b1; bit_in = 4'd2;
            end else begin
               scl_in = 1'b0; sda_in = 1'b1; ack_go = 1'b1; ack_to = 1'b1;
            end
         end
         PH_RECV: begin
            ph_in = ph;
            if (!bc[0]) begin
               scl_in = 1'b1; sda_in = 1'b1;
               sh_in = {sh_ff[6:0], cmd.sda};
               if (bc >= 4'd14) begin
                  out_in.rdata = sh_in; out_in.rvalid = 1'b1;
               end
               bit_in = bc + 4'd1;
            end else begin
               scl_in = 1'b0; sda_in = 1'b1;
               if (bc == 4'd15) begin
                  ph_in = (scnt_ff <= 3'd1) ? PH_NACKOUT : PH_ACKOUT; bit_in = 4'd0;
               end else bit_in = bc + 4'd1;
            end
         end
         PH_ACKOUT: begin
            ph_in = ph;
            if (bc == 4'd0) begin
               scl_in = 1'b0; sda_in = 1'b0; bit_in = 4'd1;
            end else if (bc == 4'd1) begin
               scl_in = 1'b1; sda_in = 1'b0; bit_in = 4'd2;
            end else if (bc == 4'd2) begin
               scl_in = 1'b0; sda_in = 1'b0; bit_in = 4'd3;
            end else begin
               scl_in = 1'b0; sda_in = 1'b1;
               if (scnt_ff != 3'd0) scnt_in = scnt_ff - 3'd1;
               sh_in = 8'd0; ph_in = PH_RECV; bit_in = 4'd0;
            end
         end
         PH_NACKOUT: begin
            ph_in = ph;
            if (bc == 4'd0) begin
               scl_in = 1'b0; sda_in = 1'b1; bit_in = 4'd1;
            end else if (bc == 4'd1) begin
               scl_in = 1'b1; sda_in = 1'b1; bit_in = 4'd2;
            end else begin
               scl_in = 1'b0; sda_in = 1'b1;
               if (scnt_ff != 3'd0) scnt_in = scnt_ff - 3'd1;
               ph_in = PH_STOP; bit_in = 4'd0;
            end
         end
         PH_STOP: begin
            ph_in = ph;
            if (bc == 4'd0) begin
               sda_in = 1'b0; bit_in = 4'd1;
            end else if (bc == 4'd1) begin
               scl_in = 1'b1; sda_in = 1'b0; bit_in = 4'd2;
            end else begin
               scl_in = 1'b1; sda_in = 1'b1; out_in.done = 1'b1;
               ph_in = PH_IDLE; bit_in = 4'd0;
            end
         end
         default: begin
            ph_in = PH_IDLE; bit_in = 4'd0;
         end
      endcase
      if (ack_go) begin
         bit_in = 4'd0;
         unique case (byte_ff)
            3'd0: begin byte_in = 3'd1; sh_in = sreg_ff[15:8]; ph_in = PH_SEND; end
            3'd1: begin byte_in = 3'd2; sh_in = sreg_ff[7:0]; ph_in = PH_SEND; end
            3'd2: begin
               if (rd_ff) begin
                  byte_in = 3'd3; ph_in = PH_START;
               end else begin
                  byte_in = 3'd4;
                  ph_in = (scnt_ff == 3'd0) ? PH_STOP : PH_SEND;
                  sh_in = pend_ff[7:0];
               end
            end
            3'd3: begin
               byte_in = 3'd4; sh_in = 8'd0;
               ph_in = (scnt_ff == 3'd0) ? PH_STOP : PH_RECV;
            end
            default: begin
               scnt_in = (scnt_ff != 3'd0) ? scnt_ff - 3'd1 : scnt_ff;
               pend_in = {8'd0, pend_ff[31:8]};
               ph_in = (ack_to || scnt_in == 3'd0) ? PH_STOP : PH_SEND;
               sh_in = pend_in[7:0];
            end
         endcase
      end
      out_in.scl = scl_in;
      out_in.sda = sda_in;
      out_in.err = err_in;
      out_in.busy = (ph_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff <= 7'd20; tmo_ff <= 8'd250;
         ph_ff <= PH_IDLE; bit_ff <= '0; byte_ff <= '0; sh_ff <= '0; wait_ff <= '0;
         pend_ff <= '0; sreg_ff <= '0; scnt_ff <= '0; rd_ff <= 1'b0; err_ff <= 1'b0;
         scl_ff <= 1'b1; sda_ff <= 1'b1; ov_ff <= 1'b0;
      end else begin
         if (csr_write_enable && csr_index == CSR_DEV_ADDR) dev_ff <= csr_write_data[6:0];
         if (csr_write_enable && csr_index == CSR_ACK_TMO) tmo_ff <= csr_write_data;
         if (fire) begin
            ph_ff <= ph_in; bit_ff <= bit_in; byte_ff <= byte_in; sh_ff <= sh_in;
            wait_ff <= wait_in; pend_ff <= pend_in; sreg_ff <= sreg_in;
            scnt_ff <= scnt_in; rd_ff <= rd_in; err_ff <= err_in;
            scl_ff <= scl_in; sda_ff <= sda_in;
         end
         if (cmd_ready) ov_ff <= fire;
      end
      if (fire) out_ff <= out_in;
   end

   `ASSERT_IMPL(a_hold, clock, reset, (ov_ff && !rsp_ready) |=> $stable(out_ff),
      "result changed while stalled")
   `ASSERT_IMPL(a_idle_rel, clock, reset, (ph_ff == PH_IDLE) |-> (scl_ff && sda_ff),
      "lines not released when idle")
   `ASSERT_IMPL(a_done_idle, clock, reset, (ov_ff && out_ff.done) |-> !out_ff.busy,
      "done while still busy")
endmodule
`default_nettype wire

/* rtl/i2c_register_access_master_top.sv */
// ----------------------------------------------------------------------------
// I2C register access master
// Open-drain I2C master for 16-bit register reads and writes, tick paced.
// ----------------------------------------------------------------------------
// Every req word is one bus delay interval: actions 0 and 3 are plain ticks, 1 and 2
// start a register read or write when the master is idle. Each req word gives
// exactly one rsp word with the line levels, any finished read byte, done,
// error and busy flags.
// Throughput: one word per cycle while rsp_ready is high, set by the phase update
// in the bus sequencer. A req word passes the front register, then the queue,
// then the result register before rsp_valid rises.
// The csr port writes device address (index 0) and ack timeout (index 1);
// write only while no word is in flight.
// Reset clears all control state, releases both lines and loads address 20
// and timeout 250.
// When rsp_ready is low the result register holds, the queue fills and
// req_ready drops; no word is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
module i2c_register_access_master_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [15:0] req_reg_addr,
   input  wire logic [31:0] req_write_data,
   input  wire logic [2:0]  req_byte_count,
   input  wire logic        req_sda_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_scl_out,
   output logic             rsp_sda_out,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_read_valid,
   output logic             rsp_done_res,
   output logic             rsp_ack_error,
   output logic             rsp_busy_res
);
   import i2c_ram_pkg::*;

   cmd_type f_cmd, q_cmd;
   logic    f_valid, f_ready, q_valid, q_ready;
   rsp_type rsp;

   i2c_ram_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_action, .req_reg_addr,
      .req_write_data, .req_byte_count, .req_sda_in,
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
   );

   i2c_ram_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
   );

   i2c_ram_seq u_seq (
      .clock, .reset, .csr_write_enable, .csr_index, .csr_write_data,
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .rsp_valid, .rsp_ready, .rsp
   );

   assign rsp_scl_out = rsp.scl;
   assign rsp_sda_out = rsp.sda;
   assign rsp_read_data = rsp.rdata;
   assign rsp_read_valid = rsp.rvalid;
   assign rsp_done_res = rsp.done;
   assign rsp_ack_error = rsp.err;
   assign rsp_busy_res = rsp.busy;
endmodule
`default_nettype wire

/* tb/i2c_register_access_master_top_tb.sv */
// ----------------------------------------------------------------------------
// I2C register access master testbench
// Drives tick, read and write words with a modeled SDA slave, predicts every
// result word with a cycle model of the bus sequencer and checks each field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class i2c_bus_scoreboard;
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic [7:0] rdata;
      logic       rvalid;
      logic       done;
      logic       err;
      logic       busy;
   } bus_word_type;

   logic [6:0]  dev_addr;
   logic [7:0]  ack_limit;
   i2c_ram_pkg::phase_type ph;
   logic [3:0]  bit_cnt;
   logic [2:0]  byte_idx;
   logic [7:0]  shifter;
   logic [7:0]  wait_cnt;
   logic [31:0] data_left;
   logic [15:0] reg_hold;
   logic [2:0]  count_left;
   logic        reading;
   logic        err_flag;
   logic        scl_lvl;
   logic        sda_lvl;
   bus_word_type expected_words[$];
   int          mismatches;

   function new();
      dev_addr = 7'd20;
      ack_limit = 8'd250;
      ph = i2c_ram_pkg::PH_IDLE;
      bit_cnt = 0; byte_idx = 0; shifter = 0; wait_cnt = 0; data_left = 0;
      reg_hold = 0; count_left = 0; reading = 0; err_flag = 0;
      scl_lvl = 1; sda_lvl = 1;
      mismatches = 0;
   endfunction

   function void set_csr(logic idx, logic [7:0] v);
      if (idx == i2c_ram_pkg::CSR_DEV_ADDR) dev_addr = v[6:0];
      else ack_limit = v;
   endfunction

   function void goto(i2c_ram_pkg::phase_type p);
      ph = p;
      bit_cnt = 0;
   endfunction

   function void send_byte(logic [7:0] b);
      shifter = b;
      goto(i2c_ram_pkg::PH_SEND);
   endfunction

   function void data_or_stop();
      if (count_left == 0) goto(i2c_ram_pkg::PH_STOP);
      else send_byte(data_left[7:0]);
   endfunction

   function void ack_done(logic timed_out);
      case (byte_idx)
         3'd0: begin
            byte_idx = 1; send_byte(reg_hold[15:8]);
         end
         3'd1: begin
            byte_idx = 2; send_byte(reg_hold[7:0]);
         end
         3'd2: begin
            byte_idx = reading ? 3'd3 : 3'd4;
            if (reading) goto(i2c_ram_pkg::PH_START);
            else data_or_stop();
         end
         3'd3: begin
            byte_idx = 4; shifter = 0;
            goto(count_left == 0 ? i2c_ram_pkg::PH_STOP : i2c_ram_pkg::PH_RECV);
         end
         default: begin
            if (count_left != 0) count_left--;
            data_left = data_left >> 8;
            if (timed_out) goto(i2c_ram_pkg::PH_STOP);
            else data_or_stop();
         end
      endcase
   endfunction

   function void lines(logic c, logic d);
      scl_lvl = c;
      sda_lvl = d;
   endfunction

   // one tick of bus time
   function void note_word(logic [1:0] act, logic [15:0] ra, logic [31:0] wd,
                           logic [2:0] cnt, logic sda);
      bus_word_type w;
      logic [3:0] bc;
      w = '0;
      if (ph == i2c_ram_pkg::PH_IDLE &&
          (act == i2c_ram_pkg::ACT_READ || act == i2c_ram_pkg::ACT_WRITE)) begin
         count_left = (cnt > i2c_ram_pkg::MAX_BYTES) ? 3'(i2c_ram_pkg::MAX_BYTES) : cnt;
         reg_hold = ra; data_left = wd;
         reading = (act == i2c_ram_pkg::ACT_READ);
         err_flag = 0; byte_idx = 0; wait_cnt = 0;
         goto(i2c_ram_pkg::PH_START);
      end
      bc = bit_cnt;
      case (ph)
         i2c_ram_pkg::PH_START: begin
            if (bc == 0) begin
               lines(1, 1); bit_cnt++;
            end else if (bc == 1) begin
               lines(1, 0); bit_cnt++;
            end else begin
               lines(0, 0);
               send_byte({dev_addr, byte_idx == 3});
            end
         end
         i2c_ram_pkg::PH_SEND: begin
            if (!bc[0]) begin
               lines(0, shifter[7]); bit_cnt++;
            end else begin
               lines(1, sda_lvl);
               shifter = shifter << 1;
               if (bc >= 15) goto(i2c_ram_pkg::PH_ACKW);
               else bit_cnt++;
            end
         end
         i2c_ram_pkg::PH_ACKW: begin
            if (bc == 0) begin
               lines(0, 1); bit_cnt++;
            end else begin
               lines(1, 1); wait_cnt = 0; goto(i2c_ram_pkg::PH_POLL);
            end
         end
         i2c_ram_pkg::PH_POLL: begin
            if (!sda) begin
               lines(0, 1); ack_done(0);
            end else if (wait_cnt >= ack_limit) begin
               err_flag = 1; lines(1, 0); goto(i2c_ram_pkg::PH_TOSTOP);
            end else begin
               wait_cnt++; lines(1, 1);
            end
         end
         i2c_ram_pkg::PH_TOSTOP: begin
            if (bc == 0) begin
               lines(1, 0); bit_cnt++;
            end else if (bc == 1) begin
               lines(1, 1); bit_cnt++;
            end else begin
               lines(0, 1); ack_done(1);
            end
         end
         i2c_ram_pkg::PH_RECV: begin
            if (!bc[0]) begin
               lines(1, 1);
               shifter = {shifter[6:0], sda};
               if (bc >= 14) begin
                  w.rdata = shifter; w.rvalid = 1;
               end
               bit_cnt++;
            end else begin
               lines(0, 1);
               if (bc >= 15)
                  goto(count_left <= 1 ? i2c_ram_pkg::PH_NACKOUT : i2c_ram_pkg::PH_ACKOUT);
               else bit_cnt++;
            end
         end
         i2c_ram_pkg::PH_ACKOUT: begin
            if (bc == 0) begin
               lines(0, 0); bit_cnt++;
            end else if (bc == 1) begin
               lines(1, 0); bit_cnt++;
            end else if (bc == 2) begin
               lines(0, 0); bit_cnt++;
            end else begin
               lines(0, 1);
               if (count_left != 0) count_left--;
               shifter = 0; goto(i2c_ram_pkg::PH_RECV);
            end
         end
         i2c_ram_pkg::PH_NACKOUT: begin
            if (bc == 0) begin
               lines(0, 1); bit_cnt++;
            end else if (bc == 1) begin
               lines(1, 1); bit_cnt++;
            end else begin
               lines(0, 1);
               if (count_left != 0) count_left--;
               goto(i2c_ram_pkg::PH_STOP);
            end
         end
         i2c_ram_pkg::PH_STOP: begin
            if (bc == 0) begin
               lines(scl_lvl, 0); bit_cnt++;
            end else if (bc == 1) begin
               lines(1, 0); bit_cnt++;
            end else begin
               lines(1, 1); w.done = 1; goto(i2c_ram_pkg::PH_IDLE);
            end
         end
         default: goto(i2c_ram_pkg::PH_IDLE);
      endcase
      w.scl = scl_lvl; w.sda = sda_lvl; w.err = err_flag;
      w.busy = (ph != i2c_ram_pkg::PH_IDLE);
      expected_words.push_back(w);
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   task check_word(bus_word_type got);
      bus_word_type want;
      if (expected_words.size() == 0) begin
         report("unexpected word", 32'(got), 32'd0);
         return;
      end
      want = expected_words.pop_front();
      if (got.scl != want.scl) report("scl_out", 32'(got.scl), 32'(want.scl));
      if (got.sda != want.sda) report("sda_out", 32'(got.sda), 32'(want.sda));
      if (got.rdata != want.rdata) report("read_data", 32'(got.rdata), 32'(want.rdata));
      if (got.rvalid != want.rvalid)
         report("read_valid", 32'(got.rvalid), 32'(want.rvalid));
      if (got.done != want.done) report("done_res", 32'(got.done), 32'(want.done));
      if (got.err != want.err) report("ack_error", 32'(got.err), 32'(want.err));
      if (got.busy != want.busy) report("busy_res", 32'(got.busy), 32'(want.busy));
   endtask
endclass

module i2c_register_access_master_top_tb;
   localparam int STALL_LIMIT = 5000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write_enable = 0;
   logic        csr_index = 0;
   logic [7:0]  csr_write_data = 0;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_action = 0;
   logic [15:0] req_reg_addr = 0;
   logic [31:0] req_write_data = 0;
   logic [2:0]  req_byte_count = 0;
   logic        req_sda_in = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_scl_out, rsp_sda_out, rsp_read_valid, rsp_done_res;
   logic        rsp_ack_error, rsp_busy_res;
   logic [7:0]  rsp_read_data;

   i2c_bus_scoreboard sb = new();
   int  idle_cycles = 0;
   bit  rx_stall_on = 1;
   int  slave_mode = 0; // 0 acks, 1 random, 2 never acks

   i2c_register_access_master_top dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_word({rsp_scl_out, rsp_sda_out, rsp_read_data, rsp_read_valid,
                           rsp_done_res, rsp_ack_error, rsp_busy_res});
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
         rsp_ready <= rx_stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
   end

   task automatic send_word(logic [1:0] act, logic [15:0] ra, logic [31:0] wd,
                            logic [2:0] cnt, logic sda);
      req_valid <= 1; req_action <= act; req_reg_addr <= ra;
      req_write_data <= wd; req_byte_count <= cnt; req_sda_in <= sda;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(act, ra, wd, cnt, sda);
   endtask

   task automatic pause_sender();
      req_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   // sda level the slave would give this tick
   function automatic logic slave_sda();
      if (sb.ph == i2c_ram_pkg::PH_POLL) begin
         if (slave_mode == 2) return 1;
         if (slave_mode == 1) return $urandom_range(0, 3) == 0;
         return 0;
      end
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic run_transaction(logic [1:0] act, logic [15:0] ra, logic [31:0] wd,
                                  logic [2:0] cnt, bit gaps);
      int burst;
      burst = $urandom_range(1, 30);
      send_word(act, ra, wd, cnt, slave_sda());
      while (sb.ph != i2c_ram_pkg::PH_IDLE) begin
         if (gaps) begin
            burst--;
            if (burst == 0) begin
               pause_sender();
               burst = $urandom_range(1, 30);
            end
         end
         send_word(2'($urandom_range(0, 3)), 16'($urandom), $urandom, 3'($urandom),
                   slave_sda());
      end
   endtask

   task automatic write_csr(logic idx, logic [7:0] v);
      req_valid <= 0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_enable <= 1; csr_index <= idx; csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      sb.set_csr(idx, v);
   endtask

   initial begin
      int n;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      rx_stall_on = 0;
      send_word(i2c_ram_pkg::ACT_TICK, 0, 0, 0, 1);
      run_transaction(i2c_ram_pkg::ACT_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 3'd4, 0);
      run_transaction(i2c_ram_pkg::ACT_READ, 16'h0000, 0, 3'd4, 0);
      run_transaction(i2c_ram_pkg::ACT_WRITE, 16'h1234, 32'hA5, 3'd0, 0);
      run_transaction(i2c_ram_pkg::ACT_READ, 16'h8001, 0, 3'd0, 0);
      run_transaction(i2c_ram_pkg::ACT_READ, 16'h5A5A, 0, 3'd7, 0);
      run_transaction(i2c_ram_pkg::ACT_WRITE, 16'hA5A5, 32'h0123_4567, 3'd5, 0);
      send_word(2'd3, 0, 0, 1, 0);
      write_csr(i2c_ram_pkg::CSR_DEV_ADDR, 8'h7F);
      write_csr(i2c_ram_pkg::CSR_ACK_TMO, 8'd0);
      slave_mode = 2;
      run_transaction(i2c_ram_pkg::ACT_WRITE, 16'h00FF, 32'hDEAD_BEEF, 3'd3, 0);
      run_transaction(i2c_ram_pkg::ACT_READ, 16'hFF00, 0, 3'd2, 0);
      write_csr(i2c_ram_pkg::CSR_DEV_ADDR, 8'h00);
      write_csr(i2c_ram_pkg::CSR_ACK_TMO, 8'd255);
      slave_mode = 0;
      run_transaction(i2c_ram_pkg::ACT_READ, 16'h0F0F, 0, 3'd1, 0);
      slave_mode = 1;
      write_csr(i2c_ram_pkg::CSR_ACK_TMO, 8'd3);
      run_transaction(i2c_ram_pkg::ACT_WRITE, 16'hF0F0, 32'h8000_0001, 3'd4, 0);
      // random
      rx_stall_on = 1;
      for (n = 0; n < 4; n++) begin
         if (n % 2 == 0) begin
            write_csr(i2c_ram_pkg::CSR_DEV_ADDR, 8'($urandom_range(0, 127)));
            write_csr(i2c_ram_pkg::CSR_ACK_TMO, (n % 4 == 0) ? 8'($urandom_range(0, 2))
                                                             : 8'($urandom_range(1, 31)));
            rx_stall_on = (n % 4 != 2);
         end
         slave_mode = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
         run_transaction(2'($urandom_range(1, 2)), 16'($urandom), $urandom,
                         3'($urandom_range(0, 7)), 1);
         if ($urandom_range(0, 1)) pause_sender();
      end
      req_valid <= 0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

`default_nettype wire

/* i2c_register_access_master_top.f */
+incdir+rtl
rtl/i2c_ram_pkg.sv
rtl/i2c_ram_front.sv
rtl/i2c_ram_queue.sv
rtl/i2c_ram_seq.sv
rtl/i2c_register_access_master_top.sv
tb/i2c_register_access_master_top_tb.sv
